// File: rtl/aes_kx_pkg.sv
// Shared types, constants and byte-substitution helpers for the AES-128 key expansion.
// No dependencies; every rtl/aes_kx_* module and the top level use it.
package aes_kx_pkg;

  localparam int KeyW      = 128;
  localparam int HalfW     = 64;
  localparam int RndW      = 4;
  localparam int NumStages = 11;
  localparam int NumRcon   = 10;
  localparam logic [RndW-1:0] LastRound = 4'd10;

  typedef struct packed {
    logic            valid;
    logic [RndW-1:0] rnd;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] RCON [NumRcon] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [31:0] sub_rot_word(input logic [31:0] w);
    logic [31:0] r;
    r = {w[23:0], w[31:24]};
    return {SBOX[r[31:24]], SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
  endfunction

endpackage

// File: rtl/aes_kx_round.sv
// One registered round of the key schedule: next round key from the previous one.
// Depends on aes_kx_pkg (S-box, stage_t).
module aes_kx_round (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  aes_kx_pkg::stage_t          ctrl_i,
  input  logic [aes_kx_pkg::KeyW-1:0] key_i,
  input  logic [7:0]                  rcon_i,
  output aes_kx_pkg::stage_t          ctrl_o,
  output logic [aes_kx_pkg::KeyW-1:0] key_o
);

  logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
  aes_kx_pkg::stage_t ctrl_d, ctrl_q;
  logic [aes_kx_pkg::KeyW-1:0] key_d, key_q;

  assign {w0, w1, w2, w3} = key_i;
  assign t  = aes_kx_pkg::sub_rot_word(w3) ^ {rcon_i, 24'h000000};
  assign n0 = w0 ^ t;
  assign n1 = w1 ^ n0;
  assign n2 = w2 ^ n1;
  assign n3 = w3 ^ n2;
  assign key_d = {n0, n1, n2, n3};

  always_comb begin
    ctrl_d.valid = ctrl_i.valid;
    ctrl_d.rnd   = ctrl_i.rnd + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign ctrl_o = ctrl_q;
  assign key_o  = key_q;

endmodule

// File: rtl/aes_kx_outsel.sv
// Picks the one live pipeline stage and registers it onto the result ports.
// Depends on aes_kx_pkg (stage_t, widths).
module aes_kx_outsel (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  aes_kx_pkg::stage_t           ctrl_i [aes_kx_pkg::NumStages],
  input  logic [aes_kx_pkg::KeyW-1:0]  key_i  [aes_kx_pkg::NumStages],
  output logic                         result_valid_o,
  output logic [aes_kx_pkg::HalfW-1:0] round_key_high_o,
  output logic [aes_kx_pkg::HalfW-1:0] round_key_low_o,
  output logic [aes_kx_pkg::RndW-1:0]  round_number_o,
  output logic                         last_round_o
);

  logic                             valid_d, valid_q;
  logic [aes_kx_pkg::KeyW-1:0]      key_d, key_q;
  logic [aes_kx_pkg::RndW-1:0]      rnd_d, rnd_q;
  logic [aes_kx_pkg::NumStages-1:0] live;

  always_comb begin
    valid_d = 1'b0;
    key_d   = '0;
    rnd_d   = '0;
    for (int i = 0; i < aes_kx_pkg::NumStages; i++) begin
      live[i] = ctrl_i[i].valid;
      if (ctrl_i[i].valid) begin
        valid_d = 1'b1;
        key_d   = key_d | key_i[i];
        rnd_d   = rnd_d | ctrl_i[i].rnd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rnd_q <= rnd_d;
  end

  assign result_valid_o   = valid_q;
  assign round_key_high_o = key_q[aes_kx_pkg::KeyW-1:aes_kx_pkg::HalfW];
  assign round_key_low_o  = key_q[aes_kx_pkg::HalfW-1:0];
  assign round_number_o   = rnd_q;
  assign last_round_o     = valid_q && (rnd_q == aes_kx_pkg::LastRound);

  // only one key in flight at a time
  a_one_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(live))
    else $error("more than one stage live");

  // round keys of one key come out on consecutive cycles
  a_rounds_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && rnd_q != aes_kx_pkg::LastRound) |=>
      (valid_q && rnd_q == $past(rnd_q) + 4'd1))
    else $error("round sequence broken");

  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (rnd_q <= aes_kx_pkg::LastRound))
    else $error("round number out of range");

endmodule

// File: rtl/aes128_key_expansion.sv
// AES-128 key expansion top level: key register, ten round stages, output select.
// Depends on aes_kx_pkg, aes_kx_round, aes_kx_outsel.
//
//  channel | ports                                           | handshake
//  key in  | key_high_i, key_low_i                           | start_i & !busy_o
//  rkey out| round_key_high_o/low_o, round_number_o, last_.. | result_valid_o, 1 cycle
//
// The result port gives out one round key per cycle.
// Round 0 passes the key and output registers, rounds 1..10 in the cycles after it.
// busy_o is low while round 9 is out, so keys follow with no gap.
// Reset clears only the valid bits and the stage round numbers; results cannot be stalled.
module aes128_key_expansion (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [aes_kx_pkg::HalfW-1:0] key_high_i,
  input  logic [aes_kx_pkg::HalfW-1:0] key_low_i,
  output logic                         result_valid_o,
  output logic [aes_kx_pkg::HalfW-1:0] round_key_high_o,
  output logic [aes_kx_pkg::HalfW-1:0] round_key_low_o,
  output logic [aes_kx_pkg::RndW-1:0]  round_number_o,
  output logic                         last_round_o
);

  aes_kx_pkg::stage_t          ctrl [aes_kx_pkg::NumStages];
  logic [aes_kx_pkg::KeyW-1:0] key  [aes_kx_pkg::NumStages];

  aes_kx_pkg::stage_t          ctrl0_d, ctrl0_q;
  logic [aes_kx_pkg::KeyW-1:0] key0_q;
  logic                        accept;
  logic [aes_kx_pkg::NumStages-2:0] early;

  assign accept = start_i && !busy_o;

  always_comb begin
    ctrl0_d.valid = accept;
    ctrl0_d.rnd   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl0_q <= '0;
    end else begin
      ctrl0_q <= ctrl0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key0_q <= {key_high_i, key_low_i};
    end
  end

  assign ctrl[0] = ctrl0_q;
  assign key[0]  = key0_q;

  for (genvar g = 1; g < aes_kx_pkg::NumStages; g++) begin : g_round
    aes_kx_round u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[g-1]),
      .key_i  (key[g-1]),
      .rcon_i (aes_kx_pkg::RCON[g-1]),
      .ctrl_o (ctrl[g]),
      .key_o  (key[g])
    );
  end

  always_comb begin
    for (int i = 0; i < aes_kx_pkg::NumStages - 1; i++) begin
      early[i] = ctrl[i].valid;
    end
  end

  assign busy_o = |early;

  aes_kx_outsel u_outsel (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .key_i            (key),
    .result_valid_o   (result_valid_o),
    .round_key_high_o (round_key_high_o),
    .round_key_low_o  (round_key_low_o),
    .round_number_o   (round_number_o),
    .last_round_o     (last_round_o)
  );

endmodule

// File: verif/testbench.sv
// Testbench for aes128_key_expansion: a queued key driver, a round-key monitor and a scoreboard.
// The expected round keys come from a local key schedule whose S-box is derived from GF(2^8).
// Depends on aes_kx_pkg and the aes128_key_expansion RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 20;
  localparam int RandomKeys    = 200;
  localparam int QuietTail     = 30;

  typedef struct {
    logic [aes_kx_pkg::HalfW-1:0] hi;
    logic [aes_kx_pkg::HalfW-1:0] lo;
    bit                           drain;
    bit                           no_gap;
  } key_word_t;

  typedef struct {
    logic [aes_kx_pkg::HalfW-1:0] hi;
    logic [aes_kx_pkg::HalfW-1:0] lo;
    logic [aes_kx_pkg::RndW-1:0]  rnd;
    logic                         last;
  } round_key_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start_i = 1'b0;
  logic [aes_kx_pkg::HalfW-1:0] key_high_i = '0;
  logic [aes_kx_pkg::HalfW-1:0] key_low_i = '0;
  logic                         busy_o;
  logic                         result_valid_o;
  logic [aes_kx_pkg::HalfW-1:0] round_key_high_o;
  logic [aes_kx_pkg::HalfW-1:0] round_key_low_o;
  logic [aes_kx_pkg::RndW-1:0]  round_number_o;
  logic                         last_round_o;

  key_word_t  key_q[$];
  round_key_t round_key_q[$];
  logic [7:0] sbox_tbl [256];
  logic       key_taken = 1'b0;
  int         gap_cnt = 0;
  int         stall_cnt = 0;
  int         err_cnt = 0;

  always #4 clk_i = ~clk_i;

  aes128_key_expansion u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .key_high_i       (key_high_i),
    .key_low_i        (key_low_i),
    .result_valid_o   (result_valid_o),
    .round_key_high_o (round_key_high_o),
    .round_key_low_o  (round_key_low_o),
    .round_number_o   (round_number_o),
    .last_round_o     (last_round_o)
  );

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = xtime(a);
    end
    return p;
  endfunction

  // S-box: multiplicative inverse (x^254) followed by the affine map.
  function automatic void build_sbox();
    logic [7:0] inv;
    logic [7:0] b;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gf_mul(inv, x[7:0]);
      b = inv;
      sbox_tbl[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                      ^ {b[3:0], b[7:4]} ^ 8'h63;
    end
  endfunction

  function automatic void expand_key(logic [aes_kx_pkg::HalfW-1:0] kh,
                                     logic [aes_kx_pkg::HalfW-1:0] kl);
    logic [31:0] w [4];
    logic [31:0] t;
    logic [7:0]  rc;
    round_key_t  rk;
    w[0] = kh[63:32];
    w[1] = kh[31:0];
    w[2] = kl[63:32];
    w[3] = kl[31:0];
    rc   = 8'h01;
    for (int r = 0; r < aes_kx_pkg::NumStages; r++) begin
      if (r > 0) begin
        t = {w[3][23:0], w[3][31:24]};
        t = {sbox_tbl[t[31:24]], sbox_tbl[t[23:16]], sbox_tbl[t[15:8]], sbox_tbl[t[7:0]]}
            ^ {rc, 24'h0};
        rc = xtime(rc);
        w[0] ^= t;
        w[1] ^= w[0];
        w[2] ^= w[1];
        w[3] ^= w[2];
      end
      rk.hi   = {w[0], w[1]};
      rk.lo   = {w[2], w[3]};
      rk.rnd  = r[aes_kx_pkg::RndW-1:0];
      rk.last = (rk.rnd == aes_kx_pkg::LastRound);
      round_key_q.push_back(rk);
    end
  endfunction

  function automatic void add_key(logic [aes_kx_pkg::HalfW-1:0] hi,
                                  logic [aes_kx_pkg::HalfW-1:0] lo,
                                  bit drain, bit no_gap);
    key_word_t kw;
    kw.hi     = hi;
    kw.lo     = lo;
    kw.drain  = drain;
    kw.no_gap = no_gap;
    key_q.push_back(kw);
  endfunction

  // Driver: hold start_i until the word is taken, then insert an optional idle burst.
  always @(negedge clk_i) begin
    key_word_t kw;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || key_taken) begin
      if (gap_cnt != 0) begin
        gap_cnt <= gap_cnt - 1;
        start_i <= 1'b0;
      end else if (key_q.size() != 0 && !(key_q[0].drain && round_key_q.size() != 0)) begin
        kw = key_q.pop_front();
        start_i    <= 1'b1;
        key_high_i <= kw.hi;
        key_low_i  <= kw.lo;
        if (!kw.no_gap && $urandom_range(0, 2) == 0) gap_cnt <= $urandom_range(1, 10);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor and scoreboard.
  always @(posedge clk_i) begin
    round_key_t rk;
    key_taken <= rst_ni && start_i && !busy_o;
    if (rst_ni) begin
      if (start_i && !busy_o) expand_key(key_high_i, key_low_i);
      if (result_valid_o) begin
        if (round_key_q.size() == 0) begin
          $error("unexpected round key: round_number %0d", round_number_o);
          err_cnt++;
        end else begin
          rk = round_key_q.pop_front();
          if (round_key_high_o !== rk.hi) begin
            $error("round_key_high: expected %h, actual %h", rk.hi, round_key_high_o);
            err_cnt++;
          end
          if (round_key_low_o !== rk.lo) begin
            $error("round_key_low: expected %h, actual %h", rk.lo, round_key_low_o);
            err_cnt++;
          end
          if (round_number_o !== rk.rnd) begin
            $error("round_number: expected %0d, actual %0d", rk.rnd, round_number_o);
            err_cnt++;
          end
          if (last_round_o !== rk.last) begin
            $error("last_round: expected %b, actual %b", rk.last, last_round_o);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || !rst_ni) begin
      stall_cnt <= 0;
    end else if (stall_cnt == WatchdogLimit) begin
      $display("** aes128_key_expansion: FAILED **");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    logic [aes_kx_pkg::HalfW-1:0] hi;
    logic [aes_kx_pkg::HalfW-1:0] lo;
    int                           mode;
    build_sbox();

    add_key('0, '0, 0, 0);
    add_key('1, '1, 0, 0);
    add_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 0, 0);
    add_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 0, 0);
    add_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1, 0);
    add_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 0, 0);
    add_key(64'h8000000000000000, 64'h0000000000000001, 0, 1);
    add_key(64'h0000000000000000, 64'h00000000ffffffff, 0, 1);
    add_key(64'hffffffffffffffff, 64'hffffffff00000000, 0, 1);
    add_key(64'h0123456789abcdef, 64'hfedcba9876543210, 0, 0);
    add_key(64'hffffffffffffffff, 64'h0000000000000000, 0, 0);
    add_key(64'h0000000000000000, 64'hffffffffffffffff, 0, 0);

    for (int i = 0; i < RandomKeys; i++) begin
      mode = $urandom_range(0, 9);
      hi = {$urandom(), $urandom()};
      lo = {$urandom(), $urandom()};
      if (mode == 0) begin
        hi = '0;
        lo = '0;
        if ($urandom_range(0, 1)) hi[$urandom_range(0, 63)] = 1'b1;
        else lo[$urandom_range(0, 63)] = 1'b1;
      end else if (mode == 1) begin
        lo[31:0] = {4{8'($urandom_range(0, 255))}};
      end
      add_key(hi, lo, i == RandomKeys / 2, i >= RandomKeys - QuietTail);
    end

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (key_q.size() != 0 || start_i || round_key_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0 && round_key_q.size() == 0) begin
      $display("** aes128_key_expansion: PASSED **");
    end else begin
      $display("** aes128_key_expansion: FAILED **");
    end
    $finish;
  end

endmodule

// File: aes128_key_expansion.f
rtl/aes_kx_pkg.sv
rtl/aes_kx_round.sv
rtl/aes_kx_outsel.sv
rtl/aes128_key_expansion.sv
verif/testbench.sv
